// File: src/bcc_pkg.sv
`default_nettype none

package bcc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS      = 2'd3;

  // register values after reset
  localparam logic        RST_ACTIVE_LOW   = 1'b1;
  localparam logic [15:0] RST_DEBOUNCE_MS  = 16'd50;
  localparam logic [15:0] RST_DOUBLE_CLICK = 16'd400;
  localparam logic [15:0] RST_HOLD_MS      = 16'd2000;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } bcc_event_t;

  typedef struct packed {
    logic        raw_level;
    logic [31:0] now_ms;
  } bcc_in_t;

  typedef struct packed {
    bcc_event_t event_code;
    logic       level_stable;
  } bcc_out_t;

  typedef struct packed {
    logic        active_low;
    logic [15:0] debounce_ms;
    logic [15:0] double_click_ms;
    logic [15:0] hold_ms;
  } bcc_cfg_t;

  typedef struct packed {
    logic stable_pressed;
    logic last_raw;
    logic long_done;
    logic click_waiting;
  } bcc_flags_t;

endpackage

`default_nettype wire

// File: src/bcc_step.sv
`default_nettype none

module bcc_step import bcc_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  bcc_cfg_t             cfg,
  input  bcc_in_t              item,
  input  bcc_flags_t           flags,
  input  logic [TIME_BITS-1:0] change_time,
  input  logic [TIME_BITS-1:0] press_time,
  input  logic [TIME_BITS-1:0] click_time,
  output bcc_flags_t           flags_nxt,
  output logic [TIME_BITS-1:0] change_time_nxt,
  output logic [TIME_BITS-1:0] press_time_nxt,
  output logic [TIME_BITS-1:0] click_time_nxt,
  output bcc_out_t             result
);

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] deb_t;
  logic [TIME_BITS-1:0] dbl_t;
  logic [TIME_BITS-1:0] hold_t;
  logic [TIME_BITS-1:0] press_el;
  logic [TIME_BITS-1:0] click_el;
  logic                 pressed;
  logic                 changed;
  logic                 settled;
  logic                 new_press;
  logic                 new_click;
  logic                 dbl_hit;
  bcc_event_t           ev;

  assign now_t    = TIME_BITS'(item.now_ms);
  assign deb_t    = TIME_BITS'(cfg.debounce_ms);
  assign dbl_t    = TIME_BITS'(cfg.double_click_ms);
  assign hold_t   = TIME_BITS'(cfg.hold_ms);
  assign press_el = now_t - press_time;
  assign click_el = now_t - click_time;

  assign pressed = cfg.active_low ? ~item.raw_level : item.raw_level;
  assign changed = pressed != flags.last_raw;

  // a fresh change restarts the debounce timer at zero elapsed
  assign settled = changed ? (deb_t == '0) : ((now_t - change_time) >= deb_t);
  assign dbl_hit = flags.click_waiting && (click_el <= dbl_t);

  always_comb begin
    flags_nxt          = flags;
    flags_nxt.last_raw = pressed;
    change_time_nxt    = changed ? now_t : change_time;
    press_time_nxt     = press_time;
    click_time_nxt     = click_time;
    new_press          = 1'b0;
    new_click          = 1'b0;
    ev                 = EV_NONE;
    if (settled) begin
      if (pressed != flags.stable_pressed) begin
        flags_nxt.stable_pressed = pressed;
        if (pressed) begin
          new_press           = 1'b1;
          press_time_nxt      = now_t;
          flags_nxt.long_done = 1'b0;
        end else if (!flags.long_done) begin
          if (dbl_hit) begin
            flags_nxt.click_waiting = 1'b0;
            ev                      = EV_DOUBLE;
          end else begin
            new_click               = 1'b1;
            flags_nxt.click_waiting = 1'b1;
            click_time_nxt          = now_t;
          end
        end
      end
      if (flags_nxt.stable_pressed && !flags_nxt.long_done &&
          ((new_press ? '0 : press_el) >= hold_t)) begin
        flags_nxt.long_done     = 1'b1;
        flags_nxt.click_waiting = 1'b0;
        ev                      = EV_LONG;
      end
      if (flags_nxt.click_waiting && !new_click && (click_el > dbl_t)) begin
        flags_nxt.click_waiting = 1'b0;
        ev                      = EV_CLICK;
      end
    end
  end

  assign result.event_code   = ev;
  assign result.level_stable = flags_nxt.stable_pressed;

endmodule

`default_nettype wire

// File: src/button_click_classifier_unit.sv
`default_nettype none

// button click classifier: each item is one sample of the raw button pin with a
// free-running millisecond timestamp (used modulo 2**TIME_BITS). the pressed bit
// is debounced, and every item yields exactly one result: an event code (none,
// click, double click, long press) and the debounced level after that sample.
// an item is taken into an input register and classified when the result
// register is free or being drained, by a handful of subtract-and-compare paths
// that update the classifier state and load the result register, so one item is
// accepted every clock while results are taken. the result register only blocks
// the input side while a result waits and the input register is also full.
// configuration writes take effect at once and belong in idle periods.

module button_click_classifier_unit import bcc_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bcc_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bcc_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  bcc_cfg_t             cfg_r;

  // input register
  logic                 in_valid_r;
  bcc_in_t              in_data_r;

  // classifier state
  bcc_flags_t           flags_r;
  bcc_flags_t           flags_nxt;
  logic [TIME_BITS-1:0] change_time_r;
  logic [TIME_BITS-1:0] change_time_nxt;
  logic [TIME_BITS-1:0] press_time_r;
  logic [TIME_BITS-1:0] press_time_nxt;
  logic [TIME_BITS-1:0] click_time_r;
  logic [TIME_BITS-1:0] click_time_nxt;

  // result register
  logic                 out_valid_r;
  bcc_out_t             out_data_r;
  bcc_out_t             result;

  logic                 advance;

  // the buffered item moves on when the result register is free or being drained
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_low      <= RST_ACTIVE_LOW;
      cfg_r.debounce_ms     <= RST_DEBOUNCE_MS;
      cfg_r.double_click_ms <= RST_DOUBLE_CLICK;
      cfg_r.hold_ms         <= RST_HOLD_MS;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ACTIVE_LOW:   cfg_r.active_low      <= cfg_wdata[0];
        CFG_DEBOUNCE_MS:  cfg_r.debounce_ms     <= cfg_wdata;
        CFG_DOUBLE_CLICK: cfg_r.double_click_ms <= cfg_wdata;
        CFG_HOLD_MS:      cfg_r.hold_ms         <= cfg_wdata;
        default:          cfg_r                 <= cfg_r;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // one classification step per buffered item
  bcc_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .cfg             (cfg_r),
    .item            (in_data_r),
    .flags           (flags_r),
    .change_time     (change_time_r),
    .press_time      (press_time_r),
    .click_time      (click_time_r),
    .flags_nxt       (flags_nxt),
    .change_time_nxt (change_time_nxt),
    .press_time_nxt  (press_time_nxt),
    .click_time_nxt  (click_time_nxt),
    .result          (result)
  );

  // state only moves when an item is classified; reset clears flags and timestamps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r       <= '0;
      change_time_r <= '0;
      press_time_r  <= '0;
      click_time_r  <= '0;
    end else if (advance) begin
      flags_r       <= flags_nxt;
      change_time_r <= change_time_nxt;
      press_time_r  <= press_time_nxt;
      click_time_r  <= click_time_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none

module testbench;
  import bcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any handshake before the run is declared hung
  localparam int unsigned STALL_LIMIT = 4000;
  // cycles to let pass after the last result, enough for the two-stage pipe
  localparam int unsigned SETTLE_CYCLES = 6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic     in_valid = 1'b0;
  logic     in_ready;
  bcc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  bcc_out_t out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = CFG_ACTIVE_LOW;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  button_click_classifier_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idling knobs, percent of cycles
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;

  int unsigned error_count = 0;
  int unsigned sent_total = 0;
  int unsigned quiet_cycles = 0;

  // timestamp cursor for generated samples
  logic [31:0] stamp_ms = '0;

  // classifier results still to come, oldest first
  bcc_out_t expected_results[$];

  // shadow copy of the configuration registers
  logic        cf_active_low   = RST_ACTIVE_LOW;
  logic [15:0] cf_debounce     = RST_DEBOUNCE_MS;
  logic [15:0] cf_double       = RST_DOUBLE_CLICK;
  logic [15:0] cf_hold         = RST_HOLD_MS;

  // shadow copy of the classifier state
  logic        st_stable        = 1'b0;
  logic        st_last_pressed  = 1'b0;
  logic        st_long_done     = 1'b0;
  logic        st_click_waiting = 1'b0;
  logic [31:0] t_change         = '0;
  logic [31:0] t_press          = '0;
  logic [31:0] t_click          = '0;

  // classify one sample, advancing the shadow state
  function automatic bcc_out_t classify_sample(input bcc_in_t s);
    logic       pressed;
    logic [31:0] now;
    logic [31:0] age;
    bcc_event_t ev;
    bcc_out_t   r;
    now = s.now_ms;
    pressed = cf_active_low ? ~s.raw_level : s.raw_level;
    ev = EV_NONE;
    // any change of the pressed bit restarts the debounce timer
    if (pressed != st_last_pressed) begin
      st_last_pressed = pressed;
      t_change = now;
    end
    age = now - t_change;
    // nothing else is looked at until the level has settled
    if (age >= {16'd0, cf_debounce}) begin
      if (pressed != st_stable) begin
        st_stable = pressed;
        if (st_stable) begin
          t_press = now;
          st_long_done = 1'b0;
        end else if (!st_long_done) begin
          // release after a short press: second one makes a double click
          age = now - t_click;
          if (st_click_waiting && age <= {16'd0, cf_double}) begin
            st_click_waiting = 1'b0;
            ev = EV_DOUBLE;
          end else begin
            st_click_waiting = 1'b1;
            t_click = now;
          end
        end
      end
      // long press fires once per press and drops any pending click
      age = now - t_press;
      if (st_stable && !st_long_done && age >= {16'd0, cf_hold}) begin
        st_long_done = 1'b1;
        st_click_waiting = 1'b0;
        ev = EV_LONG;
      end
      // pending click that outlived the window becomes a single click
      age = now - t_click;
      if (st_click_waiting && age > {16'd0, cf_double}) begin
        st_click_waiting = 1'b0;
        ev = EV_CLICK;
      end
    end
    r.event_code = ev;
    r.level_stable = st_stable;
    return r;
  endfunction

  // raw pin level that means the given pressed state under current polarity
  function automatic logic raw_for(input logic pressed);
    return cf_active_low ? ~pressed : pressed;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    error_count++;
  endtask

  // receiver side: random back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // result checker, compares each accepted result with the oldest expectation
  always @(posedge clk) begin
    bcc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result ev=%0d lvl=%0d",
                                  out_data.event_code, out_data.level_stable));
      end else begin
        want = expected_results.pop_front();
        if (out_data.event_code !== want.event_code)
          report_mismatch($sformatf("event_code got %0d want %0d",
                                    out_data.event_code, want.event_code));
        if (out_data.level_stable !== want.level_stable)
          report_mismatch($sformatf("level_stable got %0d want %0d",
                                    out_data.level_stable, want.level_stable));
      end
    end
  end

  // watchdog: too long without any handshake means the block is stuck
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("timeout after %0d idle cycles", quiet_cycles);
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // offer one sample, with random sender gaps, and predict at acceptance
  task automatic offer_sample(input logic raw, input logic [31:0] now);
    bcc_in_t s;
    s.raw_level = raw;
    s.now_ms = now;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(classify_sample(s));
    sent_total++;
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write, write enable left high for back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_ACTIVE_LOW:   cf_active_low = data[0];
      CFG_DEBOUNCE_MS:  cf_debounce = data;
      CFG_DOUBLE_CLICK: cf_double = data;
      CFG_HOLD_MS:      cf_hold = data;
      default: ;
    endcase
  endtask

  // program all registers; block must be idle
  task automatic apply_settings(input logic al, input logic [15:0] deb,
                                input logic [15:0] dbl, input logic [15:0] hld);
    wait_idle();
    // upper bits of the polarity write are don't-care
    write_reg(CFG_ACTIVE_LOW, {15'($urandom_range(0, 32767)), al});
    write_reg(CFG_DEBOUNCE_MS, deb);
    write_reg(CFG_DOUBLE_CLICK, dbl);
    write_reg(CFG_HOLD_MS, hld);
    cfg_we <= 1'b0;
  endtask

  // steady level for a while, spread over a few samples
  task automatic emit_run(input logic pressed, input int unsigned dur);
    int unsigned n;
    int unsigned step;
    n = $urandom_range(1, 5);
    step = dur / n;
    for (int unsigned i = 0; i < n; i++) begin
      stamp_ms += (i == n - 1) ? dur - step * (n - 1) : step;
      offer_sample(raw_for(pressed), stamp_ms);
    end
  endtask

  // contact chatter: brief excursions to the new level and back
  task automatic chatter(input logic pressed);
    int unsigned reps;
    reps = $urandom_range(0, 3);
    for (int unsigned i = 0; i < reps; i++) begin
      stamp_ms += $urandom_range(0, cf_debounce / 2);
      offer_sample(raw_for(pressed), stamp_ms);
      stamp_ms += $urandom_range(0, cf_debounce / 2);
      offer_sample(raw_for(!pressed), stamp_ms);
    end
  endtask

  // duration around a threshold: below, above, right at it, or anywhere
  function automatic int unsigned around(input logic [15:0] thr);
    int unsigned d;
    case ($urandom_range(0, 3))
      0: d = $urandom_range(0, thr);
      1: d = thr + $urandom_range(0, thr / 2 + 2);
      2: begin
        d = thr + $urandom_range(0, 2);
        if (d > 0) d = d - 1;
      end
      default: d = $urandom_range(0, 2 * thr + 2);
    endcase
    return d;
  endfunction

  // press, hold, release, quiet: one well-formed button gesture
  task automatic button_gesture();
    chatter(1'b1);
    emit_run(1'b1, cf_debounce + around(cf_hold));
    chatter(1'b0);
    emit_run(1'b0, cf_debounce + around(cf_double));
  endtask

  // random samples, sometimes with wild timestamp jumps
  task automatic noise_burst();
    int unsigned n;
    n = $urandom_range(1, 4);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        stamp_ms = $urandom();
      else
        stamp_ms += $urandom_range(0, 2 * cf_debounce + 2);
      offer_sample(1'($urandom_range(0, 1)), stamp_ms);
    end
  endtask

  task automatic run_gestures(input int unsigned n);
    int unsigned start;
    start = sent_total;
    while (sent_total - start < n) begin
      if ($urandom_range(0, 7) == 0)
        noise_burst();
      else
        button_gesture();
    end
  endtask

  // one random phase with its own settings and idling
  task automatic run_phase(input logic al, input logic [15:0] deb,
                           input logic [15:0] dbl, input logic [15:0] hld,
                           input int unsigned sidle, input int unsigned rstall,
                           input int unsigned n);
    apply_settings(al, deb, dbl, hld);
    sender_idle_pct = sidle;
    receiver_stall_pct = rstall;
    // start either anywhere or just short of the timestamp wrap
    if ($urandom_range(0, 1) == 0)
      stamp_ms = $urandom();
    else
      stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * (deb + dbl + hld) + 10);
    run_gestures(n);
  endtask

  // reset values: settle, press, click, double click, long press, wrap
  task automatic test_default_timing();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    offer_sample(1'b1, 32'd0);
    offer_sample(1'b0, 32'd10);          // unstable press
    offer_sample(1'b0, 32'd60);          // press accepted
    offer_sample(1'b1, 32'd100);
    offer_sample(1'b1, 32'd150);         // release starts pending click
    offer_sample(1'b0, 32'd200);
    offer_sample(1'b0, 32'd250);
    offer_sample(1'b1, 32'd300);
    offer_sample(1'b1, 32'd350);         // second release inside window
    offer_sample(1'b0, 32'd400);
    offer_sample(1'b0, 32'd450);
    offer_sample(1'b1, 32'd500);
    offer_sample(1'b1, 32'd550);
    offer_sample(1'b1, 32'd1000);        // window ran out: single click
    offer_sample(1'b0, 32'd1100);
    offer_sample(1'b0, 32'd1150);
    offer_sample(1'b0, 32'd3150);        // held past hold time
    offer_sample(1'b1, 32'd3200);
    offer_sample(1'b1, 32'd3250);        // release after long press, no click
    offer_sample(1'b1, 32'hFFFF_FFF0);
    offer_sample(1'b0, 32'hFFFF_FFFF);
    offer_sample(1'b0, 32'h0000_0030);   // across the wrap, still unstable
    offer_sample(1'b0, 32'h0000_0040);   // across the wrap, accepted
  endtask

  // zero debounce and zero hold: every sample settles, long press at once
  task automatic test_zero_thresholds();
    apply_settings(1'b0, 16'd0, 16'd0, 16'd0);
    offer_sample(1'b1, 32'd5);
    offer_sample(1'b0, 32'd5);
    offer_sample(1'b1, 32'd6);
  endtask

  task automatic test_slow_defaults();
    run_phase(RST_ACTIVE_LOW, RST_DEBOUNCE_MS, RST_DOUBLE_CLICK, RST_HOLD_MS,
              0, 0, 200);
  endtask

  task automatic test_active_high_sender_gaps();
    run_phase(1'b0, 16'd10, 16'd100, 16'd300, 57, 0, 200);
  endtask

  // mid-phase the sender holds off until the pipeline is empty
  task automatic test_no_debounce_with_pause();
    run_phase(1'b1, 16'd0, 16'd50, 16'd150, 0, 57, 100);
    wait_idle();
    run_gestures(100);
  endtask

  task automatic test_instant_long_press();
    run_phase(1'b0, 16'd5, 16'd0, 16'd0, 21, 21, 150);
  endtask

  task automatic test_max_thresholds();
    run_phase(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 150);
  endtask

  task automatic test_tight_timing();
    run_phase(1'b0, 16'd3, 16'd20, 16'd60, 21, 21, 200);
  endtask

  task automatic test_long_window();
    run_phase(1'b1, 16'd20, 16'd300, 16'd1000, 57, 57, 200);
  endtask

  task automatic test_mixed_extremes();
    run_phase(1'b0, 16'd1, 16'hFFFF, 16'd40, 0, 57, 150);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_timing();
    test_zero_thresholds();
    test_slow_defaults();
    test_active_high_sender_gaps();
    test_no_debounce_with_pause();
    test_instant_long_press();
    test_max_thresholds();
    test_tight_timing();
    test_long_window();
    test_mixed_extremes();

    wait_idle();
    while (expected_results.size() != 0) begin
      void'(expected_results.pop_front());
      report_mismatch("result never arrived");
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
